@@ hw/rtl/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_PRINT = 3'd1,
        OP_NL    = 3'd2,
        OP_CR    = 3'd3,
        OP_BS    = 3'd4,
        OP_TAB   = 3'd5,
        OP_MOVE  = 3'd6,
        OP_CLEAR = 3'd7
    } t_op;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        t_op        op;
        logic       rd;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
    } t_job;
endpackage
`default_nettype wire

@@ hw/rtl/text_console_writer_top.sv @@
// text console writer
// input channel: i_valid / o_stall with i_cmd, i_char_code, i_pos_col, i_pos_row;
// a transfer happens when i_valid is high and o_stall is low
// output channel: o_valid / i_stall with cursor and cell fields, one result per item
// config channel: i_cfg_valid / o_cfg_ready sets the attribute byte (reset 7)
// a front stage classifies items into a two-entry queue, a back stage runs them
// against a cell memory of ROWS*COLUMNS entries with one write and one read port
// from input transfer to o_valid an item passes the queue, then the idle, execute and
// output states of the back stage; reads add a read state, backspace and tab a state
// that writes blank cells; scroll reads and writes each upper-row cell and blanks the
// bottom row, clear blanks every cell
// the back stage runs one item at a time (idle, execute, output in the back stage)
// after reset a blanking pass over all ROWS*COLUMNS cells runs before items execute;
// items may still be queued meanwhile
// when i_stall holds, the finished result stays and the back stage waits,
// the queue then fills and o_stall rises
`default_nettype none
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [6:0]  i_pos_col,
    input  wire logic [4:0]  i_pos_row,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_cursor_col,
    output logic [4:0]       o_cursor_row,
    output logic [10:0]      o_cursor_linear,
    output logic [15:0]      o_cell_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_text_attribute
);
    logic q_valid, q_pop, busy;
    t_job q_job;
    logic [7:0] r_attr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_attr <= 8'd7;
        else if (i_cfg_valid) r_attr <= i_text_attribute;
    end

    tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_char_code(i_char_code), .i_pos_col(i_pos_col),
        .i_pos_row(i_pos_row), .o_q_valid(q_valid), .o_q_job(q_job), .i_q_pop(q_pop)
    );

    tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_job(q_job),
        .o_q_pop(q_pop), .i_attr(r_attr), .o_busy(busy), .o_valid(o_valid),
        .i_stall(i_stall), .o_cursor_col(o_cursor_col), .o_cursor_row(o_cursor_row),
        .o_cursor_linear(o_cursor_linear), .o_cell_value(o_cell_value)
    );

`ifndef SYNTHESIS
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && !busy) |=> (r_attr == $past(i_text_attribute)))
        else $error("attribute write lost");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_cursor_linear)))
        else $error("stalled result changed");
    a_reset_attr: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_attr == 8'd7)) else $error("attribute reset");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/tcw_front.sv @@
`default_nettype none
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_char_code,
    input  wire logic [6:0] i_pos_col,
    input  wire logic [4:0] i_pos_row,
    output logic            o_q_valid,
    output t_job            o_q_job,
    input  wire logic       i_q_pop
);
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job n_job;
    logic push, inr;

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign inr = (32'(i_pos_col) < COLUMNS) && (32'(i_pos_row) < ROWS);

    always_comb begin
        n_job = '0;
        n_job.ch = i_char_code;
        n_job.col = i_pos_col;
        n_job.row = i_pos_row;
        n_job.op = OP_NONE;
        unique case (t_cmd'(i_cmd))
            CMD_PUT: begin
                priority if (i_char_code == CH_NL) n_job.op = OP_NL;
                else if (i_char_code == CH_CR) n_job.op = OP_CR;
                else if (i_char_code == CH_BS) n_job.op = OP_BS;
                else if (i_char_code == CH_TAB) n_job.op = OP_TAB;
                else if (i_char_code >= CH_SPACE && i_char_code <= CH_TILDE)
                    n_job.op = OP_PRINT;
                else n_job.op = OP_NONE;
            end
            CMD_MOVE: n_job.op = inr ? OP_MOVE : OP_NONE;
            CMD_CLEAR: n_job.op = OP_CLEAR;
            CMD_READ: n_job.rd = inr;
            default: n_job.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_job = r_q[r_rp];

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop on empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_stall) else $error("full queue not stalling");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/tcw_back.sv @@
`default_nettype none
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  t_job             i_q_job,
    output logic             o_q_pop,
    input  wire logic [7:0]  i_attr,
    output logic             o_busy,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_cursor_col,
    output logic [4:0]       o_cursor_row,
    output logic [10:0]      o_cursor_linear,
    output logic [15:0]      o_cell_value
);
    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW = $clog2(CELLS);
    localparam int TW = $clog2(TAB_STOP);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_TAB   = 7'b0001000,
        S_SCRL  = 7'b0010000,
        S_READ  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rdata;
    t_state r_state;
    t_job r_job;
    logic [6:0] r_col;
    logic [4:0] r_row;
    logic [AW-1:0] r_ptr;
    logic r_sphase;
    logic r_clear;
    logic r_valid;
    logic [6:0] r_ocol;
    logic [4:0] r_orow;
    logic [10:0] r_lin;
    logic [15:0] r_cell;

    logic we, re;
    logic [AW-1:0] waddr, raddr, cur_addr;
    logic [15:0] wdata, blank;
    logic out_free;

    assign blank = {i_attr, CH_SPACE};
    assign cur_addr = AW'(32'(r_row) * COLUMNS + 32'(r_col));
    assign out_free = !r_valid || !i_stall;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_busy = (r_state != S_IDLE) || i_q_valid || r_valid;

    always_comb begin
        we = 1'b0;
        re = 1'b0;
        waddr = cur_addr;
        raddr = r_ptr;
        wdata = blank;
        unique case (r_state)
            S_INIT: begin
                we = 1'b1;
                waddr = r_ptr;
            end
            S_EXEC: begin
                if (r_job.rd) begin
                    re = 1'b1;
                    raddr = AW'(32'(r_job.row) * COLUMNS + 32'(r_job.col));
                end
                if (r_job.op == OP_PRINT) begin
                    we = 1'b1;
                    wdata = {i_attr, r_job.ch};
                end
            end
            S_TAB: we = 1'b1;
            S_SCRL: begin
                if (r_clear || 32'(r_ptr) >= CELLS - COLUMNS) begin
                    we = 1'b1;
                    waddr = r_ptr;
                end else begin
                    re = !r_sphase;
                    raddr = AW'(32'(r_ptr) + COLUMNS);
                    we = r_sphase;
                    waddr = r_ptr;
                    wdata = r_rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr <= '0;
            r_col <= '0;
            r_row <= '0;
            r_valid <= 1'b0;
            r_sphase <= 1'b0;
            r_clear <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (32'(r_ptr) == CELLS - 1) begin
                        r_ptr <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: if (i_q_valid) begin
                    r_job <= i_q_job;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    if (r_job.rd) r_state <= S_READ;
                    unique case (r_job.op)
                        OP_PRINT: begin
                            if (32'(r_col) == COLUMNS - 1) begin
                                r_col <= '0;
                                if (32'(r_row) == ROWS - 1) begin
                                    r_clear <= 1'b0;
                                    r_ptr <= '0;
                                    r_sphase <= 1'b0;
                                    r_state <= S_SCRL;
                                end else r_row <= r_row + 1'b1;
                            end else r_col <= r_col + 1'b1;
                        end
                        OP_NL: begin
                            r_col <= '0;
                            if (32'(r_row) == ROWS - 1) begin
                                r_clear <= 1'b0;
                                r_ptr <= '0;
                                r_sphase <= 1'b0;
                                r_state <= S_SCRL;
                            end else r_row <= r_row + 1'b1;
                        end
                        OP_CR: r_col <= '0;
                        OP_BS: begin
                            if (r_col != '0) r_col <= r_col - 1'b1;
                            else if (r_row != '0) begin
                                r_row <= r_row - 1'b1;
                                r_col <= 7'(COLUMNS - 1);
                            end
                            r_state <= S_TAB;
                            r_job.ch <= CH_BS;
                        end
                        OP_TAB: begin
                            r_state <= S_TAB;
                            r_job.ch <= CH_TAB;
                        end
                        OP_MOVE: begin
                            r_col <= r_job.col;
                            r_row <= r_job.row;
                        end
                        OP_CLEAR: begin
                            r_col <= '0;
                            r_row <= '0;
                            r_clear <= 1'b1;
                            r_ptr <= '0;
                            r_sphase <= 1'b1;
                            r_state <= S_SCRL;
                        end
                        default: ;
                    endcase
                end
                S_TAB: begin
                    if (r_job.ch == CH_BS) r_state <= S_OUT;
                    else if (32'(r_col) == COLUMNS - 1) begin
                        r_col <= '0;
                        if (32'(r_row) == ROWS - 1) begin
                            r_clear <= 1'b0;
                            r_ptr <= '0;
                            r_sphase <= 1'b0;
                            r_state <= S_SCRL;
                        end else begin
                            r_row <= r_row + 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                        if (r_col[TW-1:0] == TW'(TAB_STOP - 1)) r_state <= S_OUT;
                    end
                end
                S_SCRL: begin
                    if (r_clear || 32'(r_ptr) >= CELLS - COLUMNS) begin
                        r_sphase <= 1'b1;
                        r_ptr <= r_ptr + 1'b1;
                        if (32'(r_ptr) == CELLS - 1) r_state <= S_OUT;
                    end else begin
                        r_sphase <= ~r_sphase;
                        if (r_sphase) r_ptr <= r_ptr + 1'b1;
                    end
                    if (!r_clear) r_row <= 5'(ROWS - 1);
                end
                S_READ: r_state <= S_OUT;
                S_OUT: if (out_free) begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_ocol <= r_col;
            r_orow <= r_row;
            r_lin <= 11'(32'(r_row) * COLUMNS + 32'(r_col));
            r_cell <= r_job.rd ? r_rdata : 16'h0000;
        end
    end

    assign o_valid = r_valid;
    assign o_cursor_col = r_ocol;
    assign o_cursor_row = r_orow;
    assign o_cursor_linear = r_lin;
    assign o_cell_value = r_cell;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS) else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS) else $error("cursor row out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_cell)))
        else $error("result lost under stall");
`endif
endmodule
`default_nettype wire
